### rtl/core/nsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_pkg
// Shared types and constants of the nearest symbol lookup block.
// ----------------------------------------------------------------------------
package nsl_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF = 1024;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned NAME_W   = 24;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_DELTA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_EXTENT = 2'd2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } nsl_state_e;

endpackage

### rtl/core/nsl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nsl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/nearest_symbol_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_symbol_lookup_top
// Symbol table with a scanning nearest-symbol lookup.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. func_i selects a
// table write (entry_index_i, entry_value_i, entry_size_i,
// entry_name_offset_i) or a lookup of query_address_i.
// Every item gives exactly one result, shown for one cycle with done_o high;
// the receiver cannot stall, so the result must be taken in that cycle.
// A write's all-zero result follows the accepting edge and busy_o stays
// low, so items may be issued back to back.
// A lookup reads the table RAM one entry per cycle through a two-stage
// evaluate pipeline over symbol_count entries, ending early on an entry
// holding the address; the single RAM read port sets this rate. busy_o is
// high for the whole scan. The user writes configuration (cfg_we_i,
// cfg_index_i, cfg_data_i) only while idle; the block does not enforce it.
// Reset clears the registers and the control state; the table RAM is not
// cleared and entries must be written before a lookup scans them.
// ----------------------------------------------------------------------------
module nearest_symbol_lookup_top #(
  parameter int unsigned MAX_SYMBOLS = nsl_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            func_i,
  input  logic [nsl_pkg::INDEX_W-1:0]     entry_index_i,
  input  logic [nsl_pkg::ADDR_W-1:0]      entry_value_i,
  input  logic [nsl_pkg::ADDR_W-1:0]      entry_size_i,
  input  logic [nsl_pkg::NAME_W-1:0]      entry_name_offset_i,
  input  logic [nsl_pkg::ADDR_W-1:0]      query_address_i,
  input  logic                            cfg_we_i,
  input  logic [nsl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nsl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            done_o,
  output logic                            found_o,
  output logic                            exact_o,
  output logic [nsl_pkg::INDEX_W-1:0]     hit_index_o,
  output logic [nsl_pkg::ADDR_W-1:0]      base_address_o,
  output logic [nsl_pkg::NAME_W-1:0]      name_offset_o
);
  import nsl_pkg::*;

  localparam int unsigned AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned MW = 2 * ADDR_W + NAME_W;

  // configuration
  logic [COUNT_W-1:0] sym_count_q;
  logic [ADDR_W-1:0]  load_delta_q;
  logic [ADDR_W-1:0]  image_extent_q;

  // control
  nsl_state_e         state_q, state_d;
  logic [CW-1:0]      ptr_q, n_q;
  logic [ADDR_W-1:0]  query_q;
  logic               s1_vld_q, s2_vld_q, have_q;
  logic [CW-1:0]      s1_idx_q, s2_idx_q, best_idx_q;
  logic               s2_skip_q;
  logic [ADDR_W-1:0]  s2_base_q, s2_size_q, best_d_q, best_base_q;
  logic [NAME_W-1:0]  s2_name_q, best_name_q;

  // results
  logic               done_q, found_q, exact_q;
  logic [INDEX_W-1:0] hit_index_q;
  logic [ADDR_W-1:0]  base_address_q;
  logic [NAME_W-1:0]  name_offset_q;

  logic               accept, lookup_acc, write_acc, issue, finish;
  logic [CW-1:0]      n_clip;
  logic [AW-1:0]      ram_addr;
  logic [MW-1:0]      ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]  v_a, sz_a, base_a, d_b;
  logic [NAME_W-1:0]  nm_a;
  logic               skip_a, cand_b, ex_b, upd_b, last_b, found_b;

  assign busy_o     = (state_q != ST_IDLE);
  assign accept     = start_i & ~busy_o;
  assign lookup_acc = accept & (func_i == FUNC_LOOKUP);
  assign write_acc  = accept & (func_i == FUNC_WRITE) &
                      (32'(entry_index_i) < 32'(MAX_SYMBOLS));

  assign n_clip = (32'(sym_count_q) > 32'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS)
                                                        : CW'(sym_count_q);

  // table RAM: {value, size, name}
  assign ram_addr  = write_acc ? AW'(entry_index_i) : ptr_q[AW-1:0];
  assign ram_wdata = {entry_value_i, entry_size_i, entry_name_offset_i};

  nsl_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_SYMBOLS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (write_acc),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // stage a: filter and relocate
  assign {v_a, sz_a, nm_a} = ram_rdata;
  assign skip_a = (v_a == '0) | (sz_a >= image_extent_q);
  assign base_a = v_a + load_delta_q;

  // stage b: distance and best tracking
  assign d_b     = query_q - s2_base_q;
  assign cand_b  = s2_vld_q & ~s2_skip_q & ~(s2_base_q > query_q);
  assign ex_b    = cand_b & (d_b < s2_size_q);
  assign upd_b   = cand_b & (ex_b | ~have_q | (d_b < best_d_q));
  assign last_b  = (s2_idx_q == n_q - CW'(1));
  assign found_b = have_q | upd_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (lookup_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    issue  = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        issue  = 1'b0;
        finish = 1'b0;
      end
      ST_SCAN: begin
        finish = (n_q == '0) | (s2_vld_q & (ex_b | last_b));
        issue  = ~finish & (ptr_q < n_q);
      end
      default: begin
        issue  = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_count_q    <= '0;
      load_delta_q   <= '0;
      image_extent_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SYMBOL_COUNT: sym_count_q    <= cfg_data_i[COUNT_W-1:0];
        CFG_LOAD_DELTA:   load_delta_q   <= cfg_data_i[ADDR_W-1:0];
        CFG_IMAGE_EXTENT: image_extent_q <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ptr_q    <= '0;
      n_q      <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      have_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q & ~finish;
      done_q   <= finish | (accept & (func_i == FUNC_WRITE));
      if (lookup_acc) begin
        ptr_q  <= '0;
        n_q    <= n_clip;
        have_q <= 1'b0;
      end else begin
        if (issue) begin
          ptr_q <= ptr_q + CW'(1);
        end
        if (upd_b) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (lookup_acc) begin
      query_q <= query_address_i;
    end
    s1_idx_q  <= ptr_q;
    s2_idx_q  <= s1_idx_q;
    s2_skip_q <= skip_a;
    s2_base_q <= base_a;
    s2_size_q <= sz_a;
    s2_name_q <= nm_a;
    if (upd_b) begin
      best_idx_q  <= s2_idx_q;
      best_d_q    <= d_b;
      best_base_q <= s2_base_q;
      best_name_q <= s2_name_q;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (accept & (func_i == FUNC_WRITE)) begin
      found_q        <= 1'b0;
      exact_q        <= 1'b0;
      hit_index_q    <= '0;
      base_address_q <= '0;
      name_offset_q  <= '0;
    end else if (finish) begin
      found_q <= found_b;
      exact_q <= ex_b;
      if (upd_b) begin
        hit_index_q    <= INDEX_W'(s2_idx_q);
        base_address_q <= s2_base_q;
        name_offset_q  <= s2_name_q;
      end else if (have_q) begin
        hit_index_q    <= INDEX_W'(best_idx_q);
        base_address_q <= best_base_q;
        name_offset_q  <= best_name_q;
      end else begin
        hit_index_q    <= '0;
        base_address_q <= '0;
        name_offset_q  <= '0;
      end
    end
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign exact_o        = exact_q;
  assign hit_index_o    = hit_index_q;
  assign base_address_o = base_address_q;
  assign name_offset_o  = name_offset_q;

endmodule

### rtl/core/nsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_checker
// Port-level checks of the nearest symbol lookup block, bound to the top.
// ----------------------------------------------------------------------------
module nsl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            func_i,
  input logic                            done_o,
  input logic                            found_o,
  input logic                            exact_o,
  input logic [nsl_pkg::INDEX_W-1:0]     hit_index_o,
  input logic [nsl_pkg::ADDR_W-1:0]      base_address_o,
  input logic [nsl_pkg::NAME_W-1:0]      name_offset_o
);
  import nsl_pkg::*;

  // a lookup item always occupies the block
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == FUNC_LOOKUP) |=> busy_o)
    else $error("lookup item did not raise busy");

  // a write item answers in the next cycle with no hit
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == FUNC_WRITE) |=> (done_o && !found_o))
    else $error("write item result missing or marked found");

  // end of a scan is marked by its result
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("scan ended without a result");

  // results appear only once the block is idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (!exact_o && hit_index_o == '0 &&
                              base_address_o == '0 && name_offset_o == '0))
    else $error("miss result with nonzero fields");

endmodule

bind nearest_symbol_lookup_top nsl_checker u_nsl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .func_i         (func_i),
  .done_o         (done_o),
  .found_o        (found_o),
  .exact_o        (exact_o),
  .hit_index_o    (hit_index_o),
  .base_address_o (base_address_o),
  .name_offset_o  (name_offset_o)
);

### dv/tb_nearest_symbol_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_symbol_lookup_top
// Self-checking testbench for the nearest symbol lookup block.
//
// A table of directed rows runs first. It covers the reset values, the field
// extremes, relocation that wraps past zero, a zero extent, sizes at the
// extent, ties, an exact hit that beats a nearer entry, and the largest
// distance. Random phases follow. Each phase reprograms the registers while
// the block is idle and refills the scanned part of the table. It then mixes
// table writes with lookups of addresses near the symbols.
// Every item is scored against an in-bench model of the scan or a given result.
// ----------------------------------------------------------------------------
module tb_nearest_symbol_lookup_top;
  import nsl_pkg::*;

  localparam int unsigned TABLE_DEPTH  = MAX_SYMBOLS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic               func;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  value;
    logic [ADDR_W-1:0]  size;
    logic [NAME_W-1:0]  name;
    logic [ADDR_W-1:0]  addr;
  } sym_item_t;

  typedef struct packed {
    logic               found;
    logic               exact;
    logic [INDEX_W-1:0] hit_index;
    logic [ADDR_W-1:0]  base;
    logic [NAME_W-1:0]  name;
  } sym_result_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    sym_item_t             item;
    logic                  typed;
    sym_result_t           result;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic                  func_i = FUNC_WRITE;
  logic [INDEX_W-1:0]    entry_index_i = '0;
  logic [ADDR_W-1:0]     entry_value_i = '0;
  logic [ADDR_W-1:0]     entry_size_i = '0;
  logic [NAME_W-1:0]     entry_name_offset_i = '0;
  logic [ADDR_W-1:0]     query_address_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  done_o;
  logic                  found_o;
  logic                  exact_o;
  logic [INDEX_W-1:0]    hit_index_o;
  logic [ADDR_W-1:0]     base_address_o;
  logic [NAME_W-1:0]     name_offset_o;

  logic [ADDR_W-1:0]  value_tbl [TABLE_DEPTH];
  logic [ADDR_W-1:0]  size_tbl [TABLE_DEPTH];
  logic [NAME_W-1:0]  name_tbl [TABLE_DEPTH];
  logic [COUNT_W-1:0] symbol_count = '0;
  logic [ADDR_W-1:0]  load_delta = '0;
  logic [ADDR_W-1:0]  image_extent = '0;

  sym_result_t pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned err_count = 0;
  int unsigned stall_cycles = 0;
  bit          idle_enable = 1'b1;

  nearest_symbol_lookup_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .func_i              (func_i),
    .entry_index_i       (entry_index_i),
    .entry_value_i       (entry_value_i),
    .entry_size_i        (entry_size_i),
    .entry_name_offset_i (entry_name_offset_i),
    .query_address_i     (query_address_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .done_o              (done_o),
    .found_o             (found_o),
    .exact_o             (exact_o),
    .hit_index_o         (hit_index_o),
    .base_address_o      (base_address_o),
    .name_offset_o       (name_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic sym_result_t resolve_item(sym_item_t it);
    sym_result_t       res;
    int unsigned       n;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] cur_dist;
    logic [ADDR_W-1:0] best_dist;
    bit                have;
    res = '0;
    have = 1'b0;
    best_dist = '0;
    if (it.func == FUNC_WRITE) begin
      value_tbl[it.index] = it.value;
      size_tbl[it.index] = it.size;
      name_tbl[it.index] = it.name;
      return res;
    end
    n = (symbol_count > TABLE_DEPTH) ? TABLE_DEPTH : symbol_count;
    for (int i = 0; i < n; i++) begin
      if (value_tbl[i] == '0 || size_tbl[i] >= image_extent) continue;
      base = value_tbl[i] + load_delta;
      if (base > it.addr) continue;
      cur_dist = it.addr - base;
      if (cur_dist < size_tbl[i] || !have || cur_dist < best_dist) begin
        have = 1'b1;
        best_dist = cur_dist;
        res.found = 1'b1;
        res.exact = (cur_dist < size_tbl[i]);
        res.hit_index = INDEX_W'(i);
        res.base = base;
        res.name = name_tbl[i];
        if (res.exact) break;
      end
    end
    return res;
  endfunction

  task automatic send_item(sym_item_t it, logic typed, sym_result_t typed_res);
    sym_result_t res;
    cfg_we_i <= 1'b0;
    if (idle_enable && $urandom_range(0, 99) < 8) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start_i             <= 1'b1;
    func_i              <= it.func;
    entry_index_i       <= it.index;
    entry_value_i       <= it.value;
    entry_size_i        <= it.size;
    entry_name_offset_i <= it.name;
    query_address_i     <= it.addr;
    do @(posedge clk_i); while (busy_o);
    res = resolve_item(it);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_block();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // the caller's next item lowers the write enable
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SYMBOL_COUNT: symbol_count = data[COUNT_W-1:0];
      CFG_LOAD_DELTA:   load_delta = data;
      CFG_IMAGE_EXTENT: image_extent = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(int unsigned count, logic [ADDR_W-1:0] delta,
                              logic [ADDR_W-1:0] extent);
    write_reg(CFG_SYMBOL_COUNT, ($urandom & ~32'h7FF) | count);
    write_reg(CFG_LOAD_DELTA, delta);
    write_reg(CFG_IMAGE_EXTENT, extent);
    if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, $urandom);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_index = idx;
    r.cfg_data = data;
    dir_rows.push_back(r);
  endtask

  task automatic add_write(logic [INDEX_W-1:0] idx, logic [ADDR_W-1:0] value,
                           logic [ADDR_W-1:0] size, logic [NAME_W-1:0] name);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = sym_item_t'{FUNC_WRITE, idx, value, size, name, 32'h0};
    r.typed = 1'b1;
    dir_rows.push_back(r);
  endtask

  task automatic add_lookup(logic [ADDR_W-1:0] addr, logic typed, sym_result_t res);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = sym_item_t'{FUNC_LOOKUP, 10'd0, 32'h0, 32'h0, 24'h0, addr};
    r.typed = typed;
    r.result = res;
    dir_rows.push_back(r);
  endtask

  function automatic sym_item_t make_entry(logic [INDEX_W-1:0] idx,
                                           logic [ADDR_W-1:0] region);
    sym_item_t it;
    it.func = FUNC_WRITE;
    it.index = idx;
    it.name = NAME_W'($urandom);
    it.addr = $urandom;
    case ($urandom_range(0, 9))
      0: it.value = '0;
      1: it.value = $urandom;
      default: it.value = region + $urandom_range(0, 'h400);
    endcase
    case ($urandom_range(0, 9))
      0: it.size = $urandom;
      1: it.size = image_extent;
      2: it.size = '0;
      default: it.size = $urandom_range(0, 'h80);
    endcase
    return it;
  endfunction

  function automatic sym_item_t make_query(int unsigned n, logic [ADDR_W-1:0] region);
    sym_item_t         it;
    int unsigned       j;
    logic [ADDR_W-1:0] base;
    it.func = FUNC_LOOKUP;
    it.index = INDEX_W'($urandom);
    it.value = $urandom;
    it.size = $urandom;
    it.name = NAME_W'($urandom);
    it.addr = $urandom;
    if (n == 0) return it;
    j = $urandom_range(0, (n > TABLE_DEPTH ? TABLE_DEPTH : n) - 1);
    base = value_tbl[j] + load_delta;
    case ($urandom_range(0, 9))
      0, 1: ;
      2: it.addr = base - $urandom_range(1, 16);
      3: it.addr = region + load_delta + $urandom_range(0, 'h500);
      default: it.addr = base + $urandom_range(0, 'h90);
    endcase
    return it;
  endfunction

  always @(posedge clk_i) begin : score_results
    sym_result_t got;
    sym_result_t want;
    if (rst_ni && done_o) begin
      got = {found_o, exact_o, hit_index_o, base_address_o, name_offset_o};
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: found=%0d exact=%0d index=%0d base=%h name=%h",
                   got.found, got.exact, got.hit_index, got.base, got.name);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("mismatch: expected %0d/%0d/%0d/%h/%h got %0d/%0d/%0d/%h/%h",
                     want.found, want.exact, want.hit_index, want.base, want.name,
                     got.found, got.exact, got.hit_index, got.base, got.name);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || cfg_we_i) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       n;
    int unsigned       m;
    int unsigned       random_items;
    int unsigned       phase;
    logic [ADDR_W-1:0] region;
    logic [ADDR_W-1:0] delta;
    logic [ADDR_W-1:0] extent;
    bit                last_was_item;
    dir_row_t          row;

    // registers at reset, count zero
    add_lookup(32'hFFFF_FFFF, 1'b1, '0);
    add_write(10'd0, 32'h0000_1000, 32'h0000_0010, 24'hFF_FFFF);
    add_write(10'd1, 32'h0000_2000, 32'h0000_0100, 24'h00_0001);
    add_write(10'd2, 32'h0000_0000, 32'h0000_0005, 24'h00_0007);
    add_write(10'd3, 32'hFFFF_FFFF, 32'h0000_0000, 24'h0A_BCDE);
    add_write(10'd1023, 32'h1234_5678, 32'hFFFF_FFFF, 24'h12_3456);
    add_cfg(CFG_SYMBOL_COUNT, 32'd4);
    // zero extent skips every entry
    add_lookup(32'h0000_1008, 1'b1, '0);
    add_cfg(CFG_IMAGE_EXTENT, 32'hFFFF_FFFF);
    add_lookup(32'h0000_1008, 1'b1,
               sym_result_t'{1'b1, 1'b1, 10'd0, 32'h0000_1000, 24'hFF_FFFF});
    add_lookup(32'h0000_0FFF, 1'b1, '0);
    add_lookup(32'h0000_1800, 1'b0, '0);
    add_lookup(32'hFFFF_FFFF, 1'b0, '0);
    add_lookup(32'h0000_2050, 1'b0, '0);
    // relocation wraps past zero
    add_cfg(CFG_LOAD_DELTA, 32'hFFFF_F000);
    add_lookup(32'h0000_0000, 1'b0, '0);
    add_lookup(32'hFFFF_FFFF, 1'b0, '0);
    // largest distance
    add_cfg(CFG_SYMBOL_COUNT, 32'd1);
    add_lookup(32'hFFFF_FFFF, 1'b1,
               sym_result_t'{1'b1, 1'b0, 10'd0, 32'h0000_0000, 24'hFF_FFFF});
    // size at the extent
    add_cfg(CFG_IMAGE_EXTENT, 32'h0000_0010);
    add_lookup(32'h0000_0005, 1'b1, '0);
    // ties and an exact hit behind a nearer entry
    add_cfg(CFG_IMAGE_EXTENT, 32'h0000_2000);
    add_cfg(CFG_LOAD_DELTA, 32'h0000_0000);
    add_cfg(CFG_SYMBOL_COUNT, 32'hFFFF_F803);
    add_write(10'd1, 32'h0000_1000, 32'h0000_0008, 24'h00_0111);
    add_write(10'd2, 32'h0000_1F00, 32'h0000_0001, 24'h00_0222);
    add_lookup(32'h0000_1020, 1'b0, '0);
    add_lookup(32'h0000_1F80, 1'b0, '0);
    add_write(10'd3, 32'h0000_1000, 32'h0000_1000, 24'h00_0333);
    add_cfg(CFG_SYMBOL_COUNT, 32'd4);
    add_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
    add_lookup(32'h0000_1F80, 1'b0, '0);
    add_lookup(32'h0000_1004, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    last_was_item = 1'b0;
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) begin
        if (last_was_item) drain_block();
        write_reg(row.cfg_index, row.cfg_data);
        last_was_item = 1'b0;
      end else begin
        send_item(row.item, row.typed, row.result);
        last_was_item = 1'b1;
      end
    end

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain_block();
      idle_enable = !(phase >= 5 && phase <= 9);
      case ($urandom_range(0, 9))
        0: n = 0;
        1: n = $urandom_range(40, 64);
        default: n = $urandom_range(1, 20);
      endcase
      region = $urandom;
      case ($urandom_range(0, 3))
        0: delta = '0;
        1: delta = $urandom;
        2: delta = 32'h0 - region;
        default: delta = $urandom_range(0, 'hFFFF);
      endcase
      case ($urandom_range(0, 9))
        0: extent = '0;
        1: extent = 32'hFFFF_FFFF;
        2: extent = $urandom;
        default: extent = $urandom_range('h20, 'h100);
      endcase
      program_regs(n, delta, extent);
      for (int i = 0; i < n; i++) begin
        send_item(make_entry(INDEX_W'(i), region), 1'b0, '0);
        random_items++;
      end
      m = $urandom_range(10, 30);
      repeat (m) begin
        if ($urandom_range(0, 3) == 0) begin
          if (n != 0 && $urandom_range(0, 1) == 0)
            send_item(make_entry(INDEX_W'($urandom_range(0, n - 1)), region), 1'b0, '0);
          else
            send_item(make_entry(INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), region),
                      1'b0, '0);
        end else begin
          send_item(make_query(n, region), 1'b0, '0);
        end
        random_items++;
      end
      phase++;
    end

    drain_block();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/nsl_pkg.sv
rtl/core/nsl_ram.sv
rtl/core/nearest_symbol_lookup_top.sv
rtl/core/nsl_checker.sv
dv/tb_nearest_symbol_lookup_top.sv
